>>> rtl/dbc_pkg.sv
// Shared types and constants for the button debounce and chord detector.
// No dependencies; every other file of the block imports this package.
package dbc_pkg;

	localparam int TIME_WIDTH_DEFAULT = 32;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ACT_UNDO  = 2'd0,
		ACT_LEFT  = 2'd1,
		ACT_RIGHT = 2'd2,
		ACT_RESET = 2'd3
	} action_t;

	// One bit per action, indexed by the action code.
	typedef logic [3:0] act_mask_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        left_level;
		logic        right_level;
		logic        reset_level;
	} sample_t;

	typedef struct packed {
		action_t action;
		logic    last;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> rtl/button_debounce_chord_detector.sv
// Button debounce and chord detector, top level.
// Samples of three active-low buttons arrive on the sample channel (valid/stall) with a
// millisecond timestamp. Each button is debounced against the debounce_ms register,
// written through the cfg channel (valid/ready, always ready). Actions leave on the
// result channel (valid/stall): undo, left point, right point, reset, in that order,
// with last marking the final action of a sample. A sample with no action sends nothing.
// The front part takes one sample per cycle unless the queue is full and updates all
// button state in that cycle. Its action mask goes into a two-entry queue; the back
// part sends one action per cycle unless the result stalls. A sample's first action
// passes the queue entry, cur_q and out_q. The sample channel stalls only while
// the queue is full, which happens when the result receiver stalls or when samples
// carrying several actions arrive faster than one per action.
// Reset (arst_n low) sets debounce_ms to 50, all stable levels to released, the previous
// readings and change times to zero, clears the swallow count and empties the queue.
// A stalled result holds its value until it is transferred.
module button_debounce_chord_detector import dbc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample_data,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic       push;
	act_mask_t  push_mask;
	logic       pop;
	act_mask_t  pop_mask;
	fifo_stat_t stat;

	assign cfg_ready = 1'b1;
	assign sample_stall = stat.full;

	dbc_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_data(sample_data),
		.queue_full(stat.full),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.push(push),
		.push_mask(push_mask)
	);

	dbc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_mask(push_mask),
		.pop(pop),
		.pop_mask(pop_mask),
		.stat(stat)
	);

	dbc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.pop_mask(pop_mask),
		.pop(pop),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result_data(result_data)
	);

endmodule

>>> rtl/dbc_front.sv
// Front part: accepts samples, debounces the three buttons and builds the action mask.
// Depends on dbc_pkg; holds the debounce register and all button state.
module dbc_front import dbc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	input  sample_t    sample_data,
	input  logic       queue_full,
	input  logic       cfg_valid,
	input  logic [15:0] cfg_data,
	output logic       push,
	output act_mask_t  push_mask
);

	logic [15:0]           debounce_q;
	logic [2:0]            stable_q;
	logic [2:0]            prev_q;
	logic [TIME_WIDTH-1:0] chg_time_q [3];
	logic [1:0]            pend_q;

	logic                  accept;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [2:0]            raw;
	logic [2:0]            stable_nxt;
	logic [2:0]            press;
	logic [2:0]            release_b;
	logic [TIME_WIDTH-1:0] chg_time_nxt [3];
	logic [1:0]            pend_nxt;
	act_mask_t             mask;

	assign accept = sample_valid && !queue_full;

	always_comb begin
		now_t = TIME_WIDTH'(sample_data.now_ms);
		raw = {sample_data.reset_level, sample_data.right_level, sample_data.left_level};
		elapsed = '0;
		for (int b = 0; b < 3; b++) begin
			// A change of the raw level restarts this button's timer.
			chg_time_nxt[b] = (raw[b] != prev_q[b]) ? now_t : chg_time_q[b];
			elapsed = now_t - chg_time_nxt[b];
			stable_nxt[b] = stable_q[b];
			press[b] = 1'b0;
			release_b[b] = 1'b0;
			if (elapsed > TIME_WIDTH'(debounce_q) && raw[b] != stable_q[b]) begin
				stable_nxt[b] = raw[b];
				press[b] = !raw[b];
				release_b[b] = raw[b];
			end
		end

		mask = '0;
		pend_nxt = pend_q;
		if ((press[0] || press[1]) && !stable_nxt[0] && !stable_nxt[1]) begin
			mask[ACT_UNDO] = 1'b1;
			pend_nxt = 2'd2;
		end
		// Releases after an undo are swallowed until the pending count runs out.
		if (release_b[0]) begin
			if (pend_nxt != 2'd0) begin
				pend_nxt = pend_nxt - 2'd1;
			end else begin
				mask[ACT_LEFT] = 1'b1;
			end
		end
		if (release_b[1]) begin
			if (pend_nxt != 2'd0) begin
				pend_nxt = pend_nxt - 2'd1;
			end else begin
				mask[ACT_RIGHT] = 1'b1;
			end
		end
		if (release_b[2]) begin
			mask[ACT_RESET] = 1'b1;
		end
	end

	assign push = accept && (mask != '0);
	assign push_mask = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			stable_q <= 3'b111;
			prev_q <= 3'b000;
			pend_q <= 2'd0;
			for (int b = 0; b < 3; b++) begin
				chg_time_q[b] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				debounce_q <= cfg_data;
			end
			if (accept) begin
				stable_q <= stable_nxt;
				prev_q <= raw;
				pend_q <= pend_nxt;
				for (int b = 0; b < 3; b++) begin
					chg_time_q[b] <= chg_time_nxt[b];
				end
			end
		end
	end

endmodule

>>> rtl/dbc_fifo.sv
// Short queue of action masks between the front and back parts.
// Depends on dbc_pkg for the mask and status types.
module dbc_fifo import dbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  act_mask_t  push_mask,
	input  logic       pop,
	output act_mask_t  pop_mask,
	output fifo_stat_t stat
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	act_mask_t       entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign stat.full = (count_q == CntW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_mask = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/dbc_back.sv
// Back part: takes action masks from the queue and sends one action per transfer.
// Depends on dbc_pkg; owns the output register of the result channel.
module dbc_back import dbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_stat_t stat,
	input  act_mask_t  pop_mask,
	output logic       pop,
	input  logic       result_stall,
	output logic       result_valid,
	output result_t    result_data
);

	act_mask_t cur_q;
	logic      out_valid_q;
	result_t   out_q;

	logic      load;
	logic      advance;
	act_mask_t rem;
	action_t   code;

	always_comb begin
		code = ACT_RESET;
		for (int i = 3; i >= 0; i--) begin
			if (cur_q[i]) begin
				code = action_t'(i[1:0]);
			end
		end
	end

	assign load = !out_valid_q || !result_stall;
	assign advance = load && (cur_q != '0);
	// Clearing the lowest set bit leaves the actions still to send.
	assign rem = cur_q & (cur_q - 4'd1);
	assign pop = !stat.empty && ((cur_q == '0) || (advance && rem == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_q <= pop_mask;
			end else if (advance) begin
				cur_q <= rem;
			end
			if (load) begin
				out_valid_q <= (cur_q != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.action <= code;
			out_q.last <= (rem == '0);
		end
	end

	assign result_valid = out_valid_q;
	assign result_data = out_q;

endmodule
